// ===== hw/rtl/grc_pkg.sv =====
// grc_pkg: shared types and constants of the gamepad report conditioner
// no dependencies; used by the top, grc_cond, grc_slot_store and grc_result_fifo
package grc_pkg;

  localparam int SLOT_COUNT = 4;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam int RES_FIFO_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_FIFO_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_FIFO_DEPTH + 1);

  localparam logic [15:0] DEAD_ZONE_RESET = 16'd2000;

  localparam logic [1:0] EV_POLL       = 2'd0;
  localparam logic [1:0] EV_CONNECT    = 2'd1;
  localparam logic [1:0] EV_DISCONNECT = 2'd2;

  localparam logic [1:0] KIND_UPDATE     = 2'd0;
  localparam logic [1:0] KIND_CONNECT    = 2'd1;
  localparam logic [1:0] KIND_DISCONNECT = 2'd2;

  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT      = 4'd2;
  localparam logic [3:0] HAT_RIGHT_DOWN = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT       = 4'd6;
  localparam logic [3:0] HAT_LEFT_UP    = 4'd7;
  localparam logic [3:0] HAT_CENTER     = 4'd8;

  localparam logic signed [15:0] AXIS_MIN = 16'sh8000;
  localparam logic signed [15:0] AXIS_MAX = 16'sh7FFF;
  localparam logic [15:0] AXIS_LSB_CLEAR = 16'hFFFE;
  localparam logic [16:0] SCALE_HALF = 17'd16384;

  typedef struct packed {
    logic [1:0]         slot;
    logic [1:0]         link_event;
    logic [15:0]        button_mask;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
  } poll_t;

  typedef struct packed {
    logic [11:0]        pressed;
    logic signed [15:0] lx;
    logic signed [15:0] ly;
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [7:0]         trig_l;
    logic [7:0]         trig_r;
    logic [3:0]         hat;
  } report_t;

  typedef struct packed {
    report_t raw;
    report_t cond;
  } cond_pair_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] slot;
    report_t    rep;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

// ===== hw/rtl/grc_in_if.sv =====
// grc_in_if: poll word channel, valid/ready with payload
// no dependencies
interface grc_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         slot;
  logic [1:0]         link_event;
  logic [15:0]        button_mask;
  logic signed [15:0] left_x;
  logic signed [15:0] left_y;
  logic signed [15:0] right_x;
  logic signed [15:0] right_y;
  logic [7:0]         left_trigger;
  logic [7:0]         right_trigger;

  modport source(
    output valid, slot, link_event, button_mask, left_x, left_y, right_x, right_y,
           left_trigger, right_trigger,
    input  ready
  );
  modport sink(
    input  valid, slot, link_event, button_mask, left_x, left_y, right_x, right_y,
           left_trigger, right_trigger,
    output ready
  );
endinterface

// ===== hw/rtl/grc_out_if.sv =====
// grc_out_if: report word channel, valid/ready with payload
// no dependencies
interface grc_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         report_kind;
  logic [1:0]         report_slot;
  logic [11:0]        pressed_mask;
  logic signed [15:0] out_left_x;
  logic signed [15:0] out_left_y;
  logic signed [15:0] out_right_x;
  logic signed [15:0] out_right_y;
  logic [7:0]         out_left_trigger;
  logic [7:0]         out_right_trigger;
  logic [3:0]         hat_code;
  logic               last_report;

  modport source(
    output valid, report_kind, report_slot, pressed_mask, out_left_x, out_left_y,
           out_right_x, out_right_y, out_left_trigger, out_right_trigger, hat_code,
           last_report,
    input  ready
  );
  modport sink(
    input  valid, report_kind, report_slot, pressed_mask, out_left_x, out_left_y,
           out_right_x, out_right_y, out_left_trigger, out_right_trigger, hat_code,
           last_report,
    output ready
  );
endinterface

// ===== hw/rtl/gamepad_report_conditioner_top.sv =====
// gamepad_report_conditioner_top: poll register, conditioning, slot store, report queue
// depends on grc_pkg, grc_in_if, grc_out_if, grc_cond, grc_slot_store, grc_result_fifo
//
//   port        dir   handshake          word
//   in_word     in    valid/ready        one poll of one slot
//   out_word    out   valid/ready        one report, last_report marks the final one
//   cfg_wr_*    in    write enable       dead zone, 16 bit
//
// a poll is taken every cycle while the poll register is empty or the report queue
// has room for two reports; it is worked from the poll register: slot store read,
// compare and write in that same cycle, so back to back polls of one slot see each other
// a poll gives zero to two reports; the output drains one report per cycle while ready
// reset clears the slot store and the queue at once, dead zone returns to 2000
module gamepad_report_conditioner_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  grc_in_if.sink      in_word,
  grc_out_if.source   out_word
);

  logic [15:0] dz_r;
  grc_pkg::poll_t in_r;
  logic in_v_r, in_v_nxt;
  logic in_take, proc_en, room_two;
  logic slot_ok, store_we, differs, second;
  logic [grc_pkg::SLOT_IDX_W-1:0] idx;
  grc_pkg::cond_pair_t pair;
  grc_pkg::report_t prev_rep;
  grc_pkg::push_t push;
  grc_pkg::result_t conn_res, upd_res, rd_data;
  logic rd_valid;

  assign proc_en = in_v_r && room_two;
  assign in_word.ready = !in_v_r || proc_en;
  assign in_take = in_word.valid && in_word.ready;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (proc_en) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      dz_r   <= grc_pkg::DEAD_ZONE_RESET;
    end else begin
      in_v_r <= in_v_nxt;
      if (cfg_wr_en) begin
        dz_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_r.slot          <= in_word.slot;
      in_r.link_event    <= in_word.link_event;
      in_r.button_mask   <= in_word.button_mask;
      in_r.left_x        <= in_word.left_x;
      in_r.left_y        <= in_word.left_y;
      in_r.right_x       <= in_word.right_x;
      in_r.right_y       <= in_word.right_y;
      in_r.left_trigger  <= in_word.left_trigger;
      in_r.right_trigger <= in_word.right_trigger;
    end
  end

  grc_cond u_cond (
    .poll      (in_r),
    .dead_zone (dz_r),
    .pair      (pair)
  );

  assign slot_ok  = (32'(in_r.slot) < grc_pkg::SLOT_COUNT);
  assign idx      = grc_pkg::SLOT_IDX_W'(in_r.slot);
  assign store_we = proc_en && slot_ok;

  grc_slot_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .idx    (idx),
    .wr_en  (store_we),
    .wr_rep (pair.cond),
    .rd_rep (prev_rep)
  );

  always_comb begin
    differs = (pair.cond != prev_rep);
    second  = differs || (in_r.link_event == grc_pkg::EV_DISCONNECT);

    conn_res.kind = grc_pkg::KIND_CONNECT;
    conn_res.slot = in_r.slot;
    conn_res.rep  = pair.raw;
    conn_res.last = !second;

    upd_res.kind = (in_r.link_event == grc_pkg::EV_DISCONNECT) ?
                   grc_pkg::KIND_DISCONNECT : grc_pkg::KIND_UPDATE;
    upd_res.slot = in_r.slot;
    upd_res.rep  = pair.cond;
    upd_res.last = 1'b1;

    push.count  = 2'd0;
    push.first  = upd_res;
    push.second = upd_res;
    if (store_we) begin
      if (in_r.link_event == grc_pkg::EV_CONNECT) begin
        push.first = conn_res;
        push.count = second ? 2'd2 : 2'd1;
      end else begin
        push.count = second ? 2'd1 : 2'd0;
      end
    end
  end

  grc_result_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room_two (room_two),
    .rd_valid (rd_valid),
    .rd_ready (out_word.ready),
    .rd_data  (rd_data)
  );

  assign out_word.valid             = rd_valid;
  assign out_word.report_kind       = rd_data.kind;
  assign out_word.report_slot       = rd_data.slot;
  assign out_word.pressed_mask      = rd_data.rep.pressed;
  assign out_word.out_left_x        = rd_data.rep.lx;
  assign out_word.out_left_y        = rd_data.rep.ly;
  assign out_word.out_right_x       = rd_data.rep.rx;
  assign out_word.out_right_y       = rd_data.rep.ry;
  assign out_word.out_left_trigger  = rd_data.rep.trig_l;
  assign out_word.out_right_trigger = rd_data.rep.trig_r;
  assign out_word.hat_code          = rd_data.rep.hat;
  assign out_word.last_report       = rd_data.last;

  a_disconnect_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (store_we && (in_r.link_event == grc_pkg::EV_DISCONNECT)) |-> (push.count == 2'd1))
    else $error("disconnect poll without exactly one report");

  a_connect_reports: assert property (@(posedge clk) disable iff (!rst_n)
    (store_we && (in_r.link_event == grc_pkg::EV_CONNECT)) |-> (push.count != 2'd0))
    else $error("connect poll without connect report");

endmodule

// ===== hw/rtl/grc_cond.sv =====
// grc_cond: builds raw and conditioned reports from one poll word
// depends on grc_pkg
module grc_cond (
  input  grc_pkg::poll_t      poll,
  input  logic [15:0]         dead_zone,
  output grc_pkg::cond_pair_t pair
);

  function automatic logic signed [15:0] scale_pos(input logic [16:0] p);
    logic [16:0] q;
    begin
      q = (p > grc_pkg::SCALE_HALF) ? (p - 17'd1) : p;
      return 16'(q);
    end
  endfunction

  function automatic logic signed [15:0] map_x(input logic signed [15:0] v);
    begin
      if (v[15]) return v;
      return scale_pos({1'b0, v});
    end
  endfunction

  function automatic logic signed [15:0] map_y(input logic signed [15:0] v);
    logic [16:0] neg;
    begin
      neg = 17'd0 - {v[15], v};
      if (!v[15] && (v != 16'sd0)) return 16'(neg);
      return scale_pos(neg);
    end
  endfunction

  function automatic logic signed [15:0] cond_axis(input logic signed [15:0] v,
                                                    input logic [15:0] dz);
    logic [16:0] mag;
    logic signed [15:0] w;
    begin
      mag = v[15] ? (17'd0 - {v[15], v}) : {1'b0, v};
      w = (mag < {1'b0, dz}) ? 16'sd0 : v;
      if ((w != grc_pkg::AXIS_MIN) && (w != grc_pkg::AXIS_MAX)) begin
        w = w & grc_pkg::AXIS_LSB_CLEAR;
      end
      return w;
    end
  endfunction

  function automatic logic [3:0] hat_of(input logic [3:0] dir);
    logic up, dn, lf, rt;
    begin
      up = dir[0];
      dn = dir[1];
      lf = dir[2];
      rt = dir[3];
      if (up && rt) return grc_pkg::HAT_UP_RIGHT;
      if (rt && dn) return grc_pkg::HAT_RIGHT_DOWN;
      if (dn && lf) return grc_pkg::HAT_DOWN_LEFT;
      if (lf && up) return grc_pkg::HAT_LEFT_UP;
      if (up) return grc_pkg::HAT_UP;
      if (rt) return grc_pkg::HAT_RIGHT;
      if (dn) return grc_pkg::HAT_DOWN;
      if (lf) return grc_pkg::HAT_LEFT;
      return grc_pkg::HAT_CENTER;
    end
  endfunction

  grc_pkg::report_t raw;
  grc_pkg::report_t cond;

  always_comb begin
    raw.pressed = {(poll.right_trigger != 8'd0), (poll.left_trigger != 8'd0),
                   poll.button_mask[11:8], poll.button_mask[5:0]};
    raw.lx = map_x(poll.left_x);
    raw.ly = map_y(poll.left_y);
    raw.rx = map_x(poll.right_x);
    raw.ry = map_y(poll.right_y);
    raw.trig_l = poll.left_trigger;
    raw.trig_r = poll.right_trigger;
    raw.hat = hat_of(poll.button_mask[15:12]);

    cond = raw;
    cond.lx = cond_axis(raw.lx, dead_zone);
    cond.ly = cond_axis(raw.ly, dead_zone);
    cond.rx = cond_axis(raw.rx, dead_zone);
    cond.ry = cond_axis(raw.ry, dead_zone);
  end

  assign pair.raw  = raw;
  assign pair.cond = cond;

endmodule

// ===== hw/rtl/grc_slot_store.sv =====
// grc_slot_store: last conditioned report of each slot, flops cleared at reset
// depends on grc_pkg
module grc_slot_store (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [grc_pkg::SLOT_IDX_W-1:0] idx,
  input  logic                          wr_en,
  input  grc_pkg::report_t              wr_rep,
  output grc_pkg::report_t              rd_rep
);

  grc_pkg::report_t prev_r [grc_pkg::SLOT_COUNT];

  assign rd_rep = prev_r[idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < grc_pkg::SLOT_COUNT; i++) begin
        prev_r[i] <= '0;
      end
    end else if (wr_en) begin
      prev_r[idx] <= wr_rep;
    end
  end

endmodule

// ===== hw/rtl/grc_result_fifo.sv =====
// grc_result_fifo: report queue, up to two pushes and one pop per cycle
// depends on grc_pkg
module grc_result_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  grc_pkg::push_t     push,
  output logic               room_two,
  output logic               rd_valid,
  input  logic               rd_ready,
  output grc_pkg::result_t   rd_data
);

  localparam int DEPTH = grc_pkg::RES_FIFO_DEPTH;
  localparam int PW = grc_pkg::RES_PTR_W;
  localparam int CW = grc_pkg::RES_CNT_W;

  grc_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] wr_ptr_1;
  logic pop;

  assign room_two = (count_r <= CW'(DEPTH - 2));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;
  assign wr_ptr_1 = wr_ptr_r + PW'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PW'(push.count);
    rd_ptr_nxt = pop ? (rd_ptr_r + PW'(1)) : rd_ptr_r;
    count_nxt  = count_r + CW'(push.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_1] <= push.second;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.count != 2'd0) |-> room_two)
    else $error("report queue pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("report queue count beyond depth");

endmodule
